@@ rtl/core/motor_feedback_frame_decoder_assert.svh @@
// Assertion macros used by the motor feedback frame decoder top module.
// Without SYNTHESIS each macro expands to a labeled concurrent assertion.
// With SYNTHESIS each macro expands to nothing.
`ifndef MOTOR_FEEDBACK_FRAME_DECODER_ASSERT_SVH
`define MOTOR_FEEDBACK_FRAME_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MFD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfd assertion failed");

// Next-cycle implication.
`define MFD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfd assertion failed");

`else

`define MFD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MFD_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/mfd_pkg.sv @@
`default_nettype none

package mfd_pkg;

   localparam int MOTOR_COUNT = 8;
   localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

   localparam int ID_W      = 11;
   localparam int WORD_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 8;
   localparam int CURRENT_W = 14;
   localparam int TURN_W    = 18;
   localparam int TOTAL_W   = 32;

   // One full circle of the rotor sensor is 2**CIRCLE_BITS counts.
   localparam int CIRCLE_BITS = 13;
   localparam logic signed [WORD_W:0] HALF_CIRCLE = 17'sd4096;

   localparam logic signed [TURN_W-1:0] TURN_MAX = 18'sd131071;
   localparam logic signed [TURN_W-1:0] TURN_MIN = -18'sd131072;
   localparam logic [COUNT_W-1:0]       COUNT_MAX = 8'hFF;

   // x / 5 as (x * 52429) >> 18, exact for magnitudes up to 2**15.
   localparam logic [16:0] DIV5_RECIP = 17'd52429;
   localparam int          DIV5_SHIFT = 18;

   localparam logic [COUNT_W-1:0] INIT_LIMIT_RESET = 8'd50;
   localparam logic [ID_W-1:0]    BASE_ID_RESET    = 11'd513;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ID    = 1'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] status_byte;
      logic [WORD_W-1:0] current_word;
      logic [WORD_W-1:0] speed_word;
      logic [WORD_W-1:0] angle_word;
      logic [ID_W-1:0]   frame_id;
   } frame_type;

   typedef struct packed {
      logic [COUNT_W-1:0]          frame_count;
      logic [WORD_W-1:0]           angle;
      logic [WORD_W-1:0]           offset;
      logic signed [TURN_W-1:0]    turns;
      logic signed [WORD_W-1:0]    speed;
      logic signed [CURRENT_W-1:0] current;
      logic [BYTE_W-1:0]           status;
      logic signed [TOTAL_W-1:0]   total;
   } record_type;

   typedef struct packed {
      logic                   en;
      logic [MOTOR_IDX_W-1:0] idx;
      record_type             data;
   } record_write_type;

endpackage

`default_nettype wire

@@ rtl/core/mfd_current_scale.sv @@
`default_nettype none

// Signed current word divided by -5, truncated toward zero.
module mfd_current_scale (
   input  wire logic [mfd_pkg::WORD_W-1:0]           current_word,
   output logic signed [mfd_pkg::CURRENT_W-1:0]      scaled_current
);

   logic                          neg;
   logic [mfd_pkg::WORD_W-1:0]    mag;
   logic [32:0]                   prod;
   logic [mfd_pkg::CURRENT_W-1:0] quot;

   always_comb begin
      neg  = current_word[mfd_pkg::WORD_W-1];
      mag  = neg ? (~current_word + 16'd1) : current_word;
      prod = 33'(mag) * 33'(mfd_pkg::DIV5_RECIP);
      quot = prod[mfd_pkg::DIV5_SHIFT +: mfd_pkg::CURRENT_W];
      // dividing by a negative number flips the sign
      scaled_current = neg ? $signed(quot) : -$signed(quot);
   end

endmodule

`default_nettype wire

@@ rtl/core/mfd_record_update.sv @@
`default_nettype none

// Next value of one motor record for one frame.
module mfd_record_update (
   input  wire mfd_pkg::frame_type              frame,
   input  wire mfd_pkg::record_type             rec_old,
   input  wire logic [mfd_pkg::COUNT_W-1:0]     init_limit,
   output mfd_pkg::record_type                  rec_new,
   output logic                                 in_init
);

   logic signed [mfd_pkg::CURRENT_W-1:0] cur_scaled;
   logic signed [mfd_pkg::WORD_W:0]      diff;
   logic signed [mfd_pkg::TURN_W-1:0]    turns_next;
   logic signed [mfd_pkg::TOTAL_W-1:0]   turns_ext;

   mfd_current_scale u_cur (
      .current_word   (frame.current_word),
      .scaled_current (cur_scaled)
   );

   always_comb begin
      in_init = rec_old.frame_count <= init_limit;
      diff = $signed({1'b0, frame.angle_word}) - $signed({1'b0, rec_old.angle});

      // angle wrapped backward past zero: one turn back, and the other way round
      turns_next = rec_old.turns;
      priority if (diff > mfd_pkg::HALF_CIRCLE) begin
         if (rec_old.turns != mfd_pkg::TURN_MIN) turns_next = rec_old.turns - 18'sd1;
      end else if (diff < -mfd_pkg::HALF_CIRCLE) begin
         if (rec_old.turns != mfd_pkg::TURN_MAX) turns_next = rec_old.turns + 18'sd1;
      end else begin
         turns_next = rec_old.turns;
      end

      turns_ext = {turns_next[mfd_pkg::TURN_W-1], turns_next,
                   {mfd_pkg::CIRCLE_BITS{1'b0}}};

      rec_new = rec_old;
      rec_new.angle = frame.angle_word;
      if (rec_old.frame_count != mfd_pkg::COUNT_MAX)
         rec_new.frame_count = rec_old.frame_count + 8'd1;

      if (in_init) begin
         rec_new.offset = frame.angle_word;
      end else begin
         rec_new.speed   = $signed(frame.speed_word);
         rec_new.current = cur_scaled;
         rec_new.status  = frame.status_byte;
         rec_new.turns   = turns_next;
         rec_new.total   = turns_ext + $signed({16'd0, frame.angle_word})
                         - $signed({16'd0, rec_old.offset});
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/mfd_record_file.sv @@
`default_nettype none

// Per-motor record registers: one combinational read, one write per cycle.
module mfd_record_file (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [mfd_pkg::MOTOR_IDX_W-1:0]  rd_idx,
   output mfd_pkg::record_type                   rd_data,
   input  wire mfd_pkg::record_write_type        wr
);

   mfd_pkg::record_type rec_ff [mfd_pkg::MOTOR_COUNT];

   assign rd_data = rec_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < mfd_pkg::MOTOR_COUNT; m++) rec_ff[m] <= '0;
      end else if (wr.en) begin
         rec_ff[wr.idx] <= wr.data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/motor_feedback_frame_decoder.sv @@
// Motor feedback frame decoder.
// req_* takes one received feedback frame per beat: identifier plus payload.
// Identifiers base_frame_id .. base_frame_id+7 select a motor record; any
// other identifier is consumed and gives no result beat.
// rsp_* returns the updated record of the selected motor, one beat per hit.
// csr_* writes init_frame_limit (index 0) and base_frame_id (index 1); it is
// always ready and must only be used while the block is idle.
// A frame in the input register that hits a motor updates its record and is
// captured in the result register once that has room. Throughput: one frame per
// cycle while the receiver keeps up, set by the read-modify-write of the record
// registers between the input and result registers; the divide by -5 is a
// reciprocal multiply in the same cycle. When the receiver stalls, the result
// holds in the output register while the next frame waits in the input
// register; req_tready drops only when both are full and the waiting frame
// hits a motor. Reset clears all records, the counters and both valid flags,
// and restores init_frame_limit = 50 and base_frame_id = 513.
`default_nettype none
`include "motor_feedback_frame_decoder_assert.svh"

module motor_feedback_frame_decoder (
   input  wire logic          clock,
   input  wire logic          reset,

   input  wire logic          req_tvalid,
   output logic               req_tready,
   // [10:0] frame_id, [26:11] angle_word, [42:27] speed_word,
   // [58:43] current_word, [66:59] status_byte, [71:67] zero
   input  wire logic [71:0]   req_tdata,

   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [2:0] motor_index, [18:3] rotor_angle, [34:19] speed_value,
   // [48:35] scaled_current, [56:49] status_value, [74:57] turn_count,
   // [106:75] accum_angle, [111:107] zero
   output logic [111:0]       rsp_tdata,
   // [0] in_init
   output logic               rsp_tuser,

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mfd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [mfd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // configuration registers
   logic [mfd_pkg::COUNT_W-1:0] init_limit_ff;
   logic [mfd_pkg::ID_W-1:0]    base_id_ff;

   // input register
   logic                 in_valid_ff, in_valid_in;
   mfd_pkg::frame_type   in_frame_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [111:0]         rsp_data_ff;
   logic                 rsp_init_ff;

   logic [mfd_pkg::ID_W:0]       id_offs;
   logic                         hit;
   logic                         out_free;
   logic                         advance;
   mfd_pkg::record_type          rec_old;
   mfd_pkg::record_type          rec_new;
   logic                         in_init;
   mfd_pkg::record_write_type    rec_wr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_limit_ff <= mfd_pkg::INIT_LIMIT_RESET;
         base_id_ff    <= mfd_pkg::BASE_ID_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            mfd_pkg::CSR_INIT_LIMIT: init_limit_ff <= csr_wdata[mfd_pkg::COUNT_W-1:0];
            mfd_pkg::CSR_BASE_ID:    base_id_ff    <= csr_wdata[mfd_pkg::ID_W-1:0];
            default: ;
         endcase
      end
   end

   // Motor select: no wrap past the top identifier, so the borrow bit rejects
   // identifiers below the base.
   always_comb begin
      id_offs = {1'b0, in_frame_ff.frame_id} - {1'b0, base_id_ff};
      hit = in_valid_ff && !id_offs[mfd_pkg::ID_W]
         && (id_offs[mfd_pkg::ID_W-1:0] < 11'(mfd_pkg::MOTOR_COUNT));
   end

   // A frame leaves the input register when its result has room, or at once
   // when it hits no motor.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!hit || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (advance && hit) rsp_valid_in = 1'b1;
      else if (rsp_tready)         rsp_valid_in = 1'b0;
      else                         rsp_valid_in = rsp_valid_ff;
   end

   mfd_record_file u_records (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (id_offs[mfd_pkg::MOTOR_IDX_W-1:0]),
      .rd_data (rec_old),
      .wr      (rec_wr)
   );

   mfd_record_update u_update (
      .frame      (in_frame_ff),
      .rec_old    (rec_old),
      .init_limit (init_limit_ff),
      .rec_new    (rec_new),
      .in_init    (in_init)
   );

   always_comb begin
      rec_wr.en   = advance && hit;
      rec_wr.idx  = id_offs[mfd_pkg::MOTOR_IDX_W-1:0];
      rec_wr.data = rec_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_frame_ff <= req_tdata[66:0];
      if (advance && hit) begin
         rsp_init_ff <= in_init;
         rsp_data_ff <= {5'd0, rec_new.total, rec_new.turns, rec_new.status,
                         rec_new.current, rec_new.speed, rec_new.angle,
                         id_offs[2:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_init_ff;

   // a hit waiting on a full, stalled result register must hold off the source
   `MFD_ASSERT_IMP(a_hold_on_stall, clock, reset,
                   in_valid_ff && hit && rsp_valid_ff && !rsp_tready, !req_tready)
   // every record update produces a result beat
   `MFD_ASSERT_NXT(a_hit_gives_result, clock, reset, advance && hit, rsp_valid_ff)
   // a miss never creates or drops a result beat
   `MFD_ASSERT_NXT(a_miss_no_result, clock, reset, advance && !hit,
                   rsp_valid_ff == $past(rsp_valid_ff && !rsp_tready))

endmodule

`default_nettype wire
